FILE: hdl/sjrq_pkg.sv
// package: types, sizes and codes of the shortest-job-first ready queue
`timescale 1ns / 1ps
package sjrq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int OCC_W       = 5;
	localparam int FIELD_W     = 16;

	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_POP  = 1'b1;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;

	typedef struct packed {
		logic [FIELD_W-1:0] id;
		logic [FIELD_W-1:0] arrival;
		logic [FIELD_W-1:0] burst;
		logic [FIELD_W-1:0] remaining;
	} rec_t;

	typedef struct packed {
		logic push;
		logic pop;
	} cell_ctl_t;

	typedef struct packed {
		logic [1:0]       status;
		rec_t             rec;
		logic [OCC_W-1:0] occ;
	} res_t;

endpackage

FILE: hdl/sjrq_cell.sv
// one slot of the sorted chain: holds a record, shifts or inserts
`timescale 1ns / 1ps
module sjrq_cell (
	input  logic              clk,
	input  sjrq_pkg::cell_ctl_t ctl,
	input  logic              held,
	input  sjrq_pkg::rec_t    new_rec,
	input  logic              prev_gt,
	input  sjrq_pkg::rec_t    prev_rec,
	input  sjrq_pkg::rec_t    next_rec,
	output logic              gt,
	output sjrq_pkg::rec_t    rec
);
	import sjrq_pkg::*;

	rec_t rec_q;

	// new item goes in front of this slot when slot is empty or its key is larger
	assign gt  = !held || (rec_q.remaining > new_rec.remaining);
	assign rec = rec_q;

	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			rec_q <= next_rec;
		end else if (ctl.push && gt) begin
			if (prev_gt) begin
				rec_q <= prev_rec;
			end else begin
				rec_q <= new_rec;
			end
		end
	end

endmodule

FILE: hdl/shortest_job_ready_queue.sv
// top level: shortest-job-first ready queue built from a chain of sorted slots
//
// input channel (in_valid/in_ready): cmd 0 pushes the record given by proc_id,
// arrival_in, burst_in and remaining_in; cmd 1 pops the record with the
// smallest remaining time, the earliest pushed winning among equal keys.
// output channel (out_valid/out_ready): exactly one result per item, with a
// status (ok, pop on empty, push dropped when full), the popped record or
// zeros, and the number of records held after the item.
// every slot compares its key with the pushed key in parallel and then loads
// the new record, takes its left neighbour or holds; a pop shifts the whole
// chain one slot towards the head. so one item is taken per cycle while in_ready
// is high, and its result is registered in the output buffer.
// results wait in a two-entry output buffer: while the receiver stalls one
// more item is still taken, then in_ready drops until a result leaves.
// after reset the queue is empty and the output buffer holds no result.
`timescale 1ns / 1ps
module shortest_job_ready_queue (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         cmd,
	input  logic [sjrq_pkg::FIELD_W-1:0] proc_id,
	input  logic [sjrq_pkg::FIELD_W-1:0] arrival_in,
	input  logic [sjrq_pkg::FIELD_W-1:0] burst_in,
	input  logic [sjrq_pkg::FIELD_W-1:0] remaining_in,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [1:0]                   status,
	output logic [sjrq_pkg::FIELD_W-1:0] out_id,
	output logic [sjrq_pkg::FIELD_W-1:0] out_arrival,
	output logic [sjrq_pkg::FIELD_W-1:0] out_burst,
	output logic [sjrq_pkg::FIELD_W-1:0] out_remaining,
	output logic [sjrq_pkg::OCC_W-1:0]   occupancy
);
	import sjrq_pkg::*;

	logic             acc_in;
	logic             acc_out;
	logic             full;
	logic             empty;
	logic             do_push;
	logic             do_pop;
	cell_ctl_t        ctl;
	rec_t             new_rec;
	rec_t             zero_rec;
	rec_t             cell_rec [QUEUE_DEPTH];
	logic             cell_gt  [QUEUE_DEPTH];
	logic [CNT_W-1:0] held_count_q;
	logic [CNT_W-1:0] count_next;
	res_t             res;
	res_t             head_q;
	res_t             tail_q;
	logic [1:0]       fill_q;

	assign in_ready  = (fill_q != 2'd2);
	assign out_valid = (fill_q != 2'd0);
	assign acc_in    = in_valid && in_ready;
	assign acc_out   = out_valid && out_ready;

	assign full    = (held_count_q == CNT_W'(QUEUE_DEPTH));
	assign empty   = (held_count_q == '0);
	assign do_push = acc_in && (cmd == CMD_PUSH) && !full;
	assign do_pop  = acc_in && (cmd == CMD_POP) && !empty;
	assign ctl     = '{push: do_push, pop: do_pop};

	assign new_rec  = '{id: proc_id, arrival: arrival_in, burst: burst_in,
		remaining: remaining_in};
	assign zero_rec = '0;

	genvar gi;
	generate
		for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
			logic prev_gt;
			rec_t prev_rec;
			rec_t next_rec;
			if (gi == 0) begin : g_head
				assign prev_gt  = 1'b0;
				assign prev_rec = new_rec;
			end else begin : g_body
				assign prev_gt  = cell_gt[gi-1];
				assign prev_rec = cell_rec[gi-1];
			end
			if (gi == QUEUE_DEPTH - 1) begin : g_last
				assign next_rec = new_rec;
			end else begin : g_inner
				assign next_rec = cell_rec[gi+1];
			end
			sjrq_cell u_cell (
				.clk      (clk),
				.ctl      (ctl),
				.held     (CNT_W'(gi) < held_count_q),
				.new_rec  (new_rec),
				.prev_gt  (prev_gt),
				.prev_rec (prev_rec),
				.next_rec (next_rec),
				.gt       (cell_gt[gi]),
				.rec      (cell_rec[gi])
			);
		end
	endgenerate

	always_comb begin
		count_next = held_count_q;
		if (do_push) begin
			count_next = held_count_q + 1'b1;
		end else if (do_pop) begin
			count_next = held_count_q - 1'b1;
		end
	end

	always_comb begin
		res.occ = OCC_W'(count_next);
		res.rec = zero_rec;
		if (cmd == CMD_PUSH) begin
			res.status = full ? STAT_FULL : STAT_OK;
		end else if (empty) begin
			res.status = STAT_EMPTY;
		end else begin
			res.status = STAT_OK;
			res.rec    = cell_rec[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count_q <= '0;
		end else begin
			held_count_q <= count_next;
		end
	end

	// two-entry result buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= 2'd0;
		end else begin
			case (fill_q)
				2'd0: begin
					if (acc_in) fill_q <= 2'd1;
				end
				2'd1: begin
					if (acc_in && !acc_out) begin
						fill_q <= 2'd2;
					end else if (!acc_in && acc_out) begin
						fill_q <= 2'd0;
					end
				end
				2'd2: begin
					if (acc_out) fill_q <= 2'd1;
				end
				default: begin
					fill_q <= 2'd0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (fill_q)
			2'd0: begin
				if (acc_in) head_q <= res;
			end
			2'd1: begin
				if (acc_in && acc_out) begin
					head_q <= res;
				end else if (acc_in) begin
					tail_q <= res;
				end
			end
			2'd2: begin
				if (acc_out) head_q <= tail_q;
			end
			default: begin
				head_q <= head_q;
			end
		endcase
	end

	assign status        = head_q.status;
	assign out_id        = head_q.rec.id;
	assign out_arrival   = head_q.rec.arrival;
	assign out_burst     = head_q.rec.burst;
	assign out_remaining = head_q.rec.remaining;
	assign occupancy     = head_q.occ;

endmodule

FILE: hdl/sjrq_checker.sv
// checker on the ports of the ready queue, with its bind
`timescale 1ns / 1ps
module sjrq_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [1:0]                   status,
	input logic [sjrq_pkg::FIELD_W-1:0] out_id,
	input logic [sjrq_pkg::FIELD_W-1:0] out_arrival,
	input logic [sjrq_pkg::FIELD_W-1:0] out_burst,
	input logic [sjrq_pkg::FIELD_W-1:0] out_remaining,
	input logic [sjrq_pkg::OCC_W-1:0]   occupancy
);
	import sjrq_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(out_id)
			&& $stable(out_remaining) && $stable(occupancy))
		else $error("stalled result changed");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == STAT_OK || status == STAT_EMPTY || status == STAT_FULL))
		else $error("bad status code");

	// a failed item carries no record
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STAT_OK |-> out_id == '0 && out_arrival == '0
			&& out_burst == '0 && out_remaining == '0)
		else $error("failed item carries record data");

	// empty pop leaves nothing behind, full push reports a full queue
	a_fail_occ: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_EMPTY |-> occupancy == '0)
		else $error("empty pop with records held");

	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_FULL |-> occupancy == OCC_W'(QUEUE_DEPTH))
		else $error("dropped push with queue not full");

endmodule

bind shortest_job_ready_queue sjrq_checker u_sjrq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.status        (status),
	.out_id        (out_id),
	.out_arrival   (out_arrival),
	.out_burst     (out_burst),
	.out_remaining (out_remaining),
	.occupancy     (occupancy)
);

FILE: test/tb_shortest_job_ready_queue.sv
// testbench: directed and random push/pop traffic on the shortest-job-first queue, self-checking
`timescale 1ns / 1ps
module tb_shortest_job_ready_queue;
	import sjrq_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int MAX_WAIT    = 16;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 50;

	class queue_scoreboard;
		rec_t        held[$];
		res_t        due[$];
		int unsigned errors, pushes, pops, empties, drops, peak;

		function void note_item(logic c, rec_t r);
			res_t want;
			int   pos;
			want = '0;
			want.status = STAT_OK;
			if (c == CMD_PUSH) begin
				pushes++;
				if (held.size() >= QUEUE_DEPTH) begin
					want.status = STAT_FULL;
					drops++;
				end else begin
					// new record goes behind every held record with a key not above its own
					pos = held.size();
					while (pos > 0 && held[pos-1].remaining > r.remaining)
						pos--;
					held.insert(pos, r);
				end
			end else begin
				pops++;
				if (held.size() == 0) begin
					want.status = STAT_EMPTY;
					empties++;
				end else
					want.rec = held.pop_front();
			end
			want.occ = OCC_W'(held.size());
			if (held.size() > peak)
				peak = held.size();
			due.insert(due.size(), want);
		endfunction

		function void compare(string what, int unsigned want, int unsigned got);
			if (want != got) begin
				errors++;
				$display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
			end
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (due.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none actual status %0h id %0h",
					$time, got.status, got.rec.id);
				return;
			end
			want = due.pop_front();
			compare("status", want.status, got.status);
			compare("out_id", want.rec.id, got.rec.id);
			compare("out_arrival", want.rec.arrival, got.rec.arrival);
			compare("out_burst", want.rec.burst, got.rec.burst);
			compare("out_remaining", want.rec.remaining, got.rec.remaining);
			compare("occupancy", want.occ, got.occ);
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic               cmd;
	logic [FIELD_W-1:0] proc_id;
	logic [FIELD_W-1:0] arrival_in;
	logic [FIELD_W-1:0] burst_in;
	logic [FIELD_W-1:0] remaining_in;
	logic               out_valid;
	logic               out_ready;
	logic [1:0]         status;
	logic [FIELD_W-1:0] out_id;
	logic [FIELD_W-1:0] out_arrival;
	logic [FIELD_W-1:0] out_burst;
	logic [FIELD_W-1:0] out_remaining;
	logic [OCC_W-1:0]   occupancy;

	queue_scoreboard sb = new;
	int unsigned     cycles = 0;
	int unsigned     gap_max = MAX_WAIT;
	int unsigned     stall_max = MAX_WAIT;
	int unsigned     push_pct_of [PHASES] = '{85, 15, 50, 90, 10, 60, 35, 70};

	shortest_job_ready_queue i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.cmd           (cmd),
		.proc_id       (proc_id),
		.arrival_in    (arrival_in),
		.burst_in      (burst_in),
		.remaining_in  (remaining_in),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.out_id        (out_id),
		.out_arrival   (out_arrival),
		.out_burst     (out_burst),
		.out_remaining (out_remaining),
		.occupancy     (occupancy)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, sb.due.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic int unsigned draw_wait(int unsigned ceiling);
		return ($urandom_range(0, 2) == 0) ? $urandom_range(0, ceiling) : 0;
	endfunction

	task automatic send_item(input logic c, input rec_t r);
		int unsigned gap;
		gap = draw_wait(gap_max);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		cmd          <= c;
		proc_id      <= r.id;
		arrival_in   <= r.arrival;
		burst_in     <= r.burst;
		remaining_in <= r.remaining;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_item(c, r);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.due.size() != 0)
			@(posedge clk);
	endtask

	initial begin : result_sink
		int unsigned stall;
		res_t        got;
		out_ready <= 1'b0;
		@(posedge clk);
		forever begin
			stall = draw_wait(stall_max);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			got.status        = status;
			got.rec.id        = out_id;
			got.rec.arrival   = out_arrival;
			got.rec.burst     = out_burst;
			got.rec.remaining = out_remaining;
			got.occ           = occupancy;
			sb.check_result(got);
		end
	end

	initial begin : stimulus
		rec_t        r;
		int          ph;
		int unsigned push_pct;
		bit          narrow;
		arst_n       <= 1'b0;
		in_valid     <= 1'b0;
		cmd          <= CMD_PUSH;
		proc_id      <= '0;
		arrival_in   <= '0;
		burst_in     <= '0;
		remaining_in <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// pop on empty, then fill with extreme and tied keys
		r = '0;
		send_item(CMD_POP, r);
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			r.id      = FIELD_W'(i * 16'h1111);
			r.arrival = ~r.id;
			r.burst   = (i % 2) ? 16'hFFFF : 16'h0000;
			case (i % 4)
				0: r.remaining = 16'hFFFF;
				1: r.remaining = 16'h0000;
				2: r.remaining = 16'h8000;
				default: r.remaining = 16'h0001;
			endcase
			send_item(CMD_PUSH, r);
		end
		// push on full, then pops carrying junk payload
		r = '{id: 16'hABCD, arrival: 16'h1234, burst: 16'h5678, remaining: 16'h0000};
		send_item(CMD_PUSH, r);
		repeat (4) send_item(CMD_POP, r);
		wait_drained();

		for (ph = 0; ph < PHASES; ph++) begin
			push_pct  = push_pct_of[ph];
			narrow    = (ph % 3 == 1);
			gap_max   = (ph % 4 >= 2) ? 0 : MAX_WAIT;
			stall_max = (ph % 4 == 1 || ph % 4 == 2) ? 0 : MAX_WAIT;
			repeat (PHASE_ITEMS) begin
				r.id        = FIELD_W'($urandom);
				r.arrival   = FIELD_W'($urandom);
				r.burst     = FIELD_W'($urandom);
				r.remaining = narrow ? FIELD_W'($urandom_range(0, 3)) : FIELD_W'($urandom);
				send_item(($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP, r);
			end
			wait_drained();
		end

		repeat (8) @(posedge clk);
		$display("covered %0d items: %0d pushes (%0d dropped when full), %0d pops (%0d on empty)",
			sb.pushes + sb.pops, sb.pushes, sb.drops, sb.pops, sb.empties);
		$display("peak depth %0d of %0d, tied and spread keys, with and without idle gaps",
			sb.peak, QUEUE_DEPTH);
		if (sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: sim.f
hdl/sjrq_pkg.sv
hdl/sjrq_cell.sv
hdl/shortest_job_ready_queue.sv
hdl/sjrq_checker.sv
test/tb_shortest_job_ready_queue.sv
